FILE: rtl/core/exception_index_table_search_macros.svh
// Assertion macros used by the exception-index table search top level.
`ifndef EXCEPTION_INDEX_TABLE_SEARCH_MACROS_SVH
`define EXCEPTION_INDEX_TABLE_SEARCH_MACROS_SVH

// Check a condition in the same cycle as its trigger.
`define EITS_ASSERT_SAME(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// Check a condition in the cycle after its trigger.
`define EITS_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

FILE: rtl/core/eits_pkg.sv
// Types and constants of the exception-index table search block.
`default_nettype none

package eits_pkg;

  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned INDEX_W   = 10;
  localparam int unsigned COUNT_W   = 11;
  localparam int unsigned CFG_IDX_W = 2;

  // Input item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Entry value modes
  localparam logic MODE_OFFSET = 1'b0;
  localparam logic MODE_PREL31 = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_VALUE_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_BASE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT = 2'd2;

  typedef struct packed {
    logic               value_mode;
    logic [WORD_W-1:0]  table_base;
    logic [COUNT_W-1:0] entry_count;
  } eits_cfg_t;

  typedef struct packed {
    logic              valid;
    logic              command;
    logic [SLOT_W-1:0] slot;
    logic [WORD_W-1:0] word;
    logic [WORD_W-1:0] key;
  } eits_req_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [WORD_W-1:0]  address;
    logic               below;
  } eits_result_t;

endpackage

`default_nettype wire

FILE: rtl/core/eits_search.sv
// Entry memory and the iterative upper-bound binary search engine.
`default_nettype none

module eits_search import eits_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire eits_cfg_t    cfg_i,
  input  wire eits_req_t    req_i,
  output logic              busy_o,
  output logic              res_valid_o,
  input  wire logic         res_take_i,
  output eits_result_t      res_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_CMP  = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     lo_q, lo_d, hi_q, hi_d;
  logic [WORD_W-1:0] key_q, key_d;
  logic [AW-1:0]     mid_q;
  logic [WORD_W-1:0] mid_addr_q;
  logic [WORD_W-1:0] rd_data_q;
  logic [WORD_W-1:0] entry_mem [TABLE_DEPTH];

  logic [CW-1:0]     sat_count;
  logic [CW:0]       mid_sum;
  logic [AW-1:0]     mid_idx;
  logic [WORD_W-1:0] entry_val;
  logic [CW-1:0]     last_idx;
  logic              wr_en;
  logic              start;

  assign busy_o      = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_FIN);
  assign wr_en = req_i.valid && (req_i.command == CMD_WRITE)
              && (32'(req_i.slot) < TABLE_DEPTH);
  assign start = req_i.valid && (req_i.command == CMD_SEARCH);

  // Saturate the searched count at the table depth
  always_comb begin
    if (32'(cfg_i.entry_count) > TABLE_DEPTH) begin
      sat_count = CW'(TABLE_DEPTH);
    end else begin
      sat_count = CW'(cfg_i.entry_count);
    end
  end

  // Probe position halfway between the bounds
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid_idx = AW'(mid_sum[CW:1]);

  // Value of the probed entry, relocated in place-relative mode
  always_comb begin
    if (cfg_i.value_mode == MODE_PREL31) begin
      entry_val = {rd_data_q[30], rd_data_q[30:0]} + mid_addr_q;
    end else begin
      entry_val = rd_data_q;
    end
  end

  // Write entries and fetch the probe
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      entry_mem[AW'(req_i.slot)] <= req_i.word;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= entry_mem[mid_idx];
    end
  end

  // Hold the probe index and its byte address
  always_ff @(posedge clk_i) begin
    if (state_q == ST_READ) begin
      mid_q      <= mid_idx;
      mid_addr_q <= cfg_i.table_base + 32'(ENTRY_BYTES) * 32'(mid_idx);
    end
  end

  // Sequence the halving steps
  always_comb begin
    state_d = state_q;
    lo_d    = lo_q;
    hi_d    = hi_q;
    key_d   = key_q;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          lo_d    = '0;
          hi_d    = sat_count;
          key_d   = req_i.key;
          state_d = (sat_count == '0) ? ST_FIN : ST_READ;
        end
      end
      ST_READ: begin
        state_d = ST_CMP;
      end
      ST_CMP: begin
        if (entry_val > key_q) begin
          hi_d = CW'(mid_q);
        end else begin
          lo_d = CW'(mid_q) + CW'(1);
        end
        state_d = (hi_d > lo_d) ? ST_READ : ST_FIN;
      end
      ST_FIN: begin
        if (res_take_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      lo_q    <= '0;
      hi_q    <= '0;
      key_q   <= '0;
    end else begin
      state_q <= state_d;
      lo_q    <= lo_d;
      hi_q    <= hi_d;
      key_q   <= key_d;
    end
  end

  // Report the entry just below the upper bound
  assign last_idx = lo_q - CW'(1);

  always_comb begin
    if (lo_q == '0) begin
      res_o.index   = '0;
      res_o.address = '0;
      res_o.below   = 1'b1;
    end else begin
      res_o.index   = INDEX_W'(last_idx);
      res_o.address = cfg_i.table_base + 32'(ENTRY_BYTES) * 32'(last_idx);
      res_o.below   = 1'b0;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/exception_index_table_search.sv
// Top level of the exception-index table search block.
//
// Input channel (in_valid_i / in_stall_o): command_i selects a table write
// (entry_slot_i, entry_word_i) or a search query (search_key_i). A write gives
// no result. A query runs an upper-bound binary search over the first
// entry_count entries, capped at TABLE_DEPTH; each halving step reads the
// entry memory, then compares the probed entry with the key. A query over N
// entries runs at most ceil(log2(N+1)) steps.
// in_stall_o stays high while a query is in flight.
// Output channel (out_valid_o / out_stall_i): one result per query, held in
// an output register until transferred. A finished query moves into that
// register only once it is free or being transferred, so a stalled receiver
// holds the engine in its last step and the input stalls behind it.
// Configuration (cfg_valid_i / cfg_ready_o): always ready; write registers
// only while no query is outstanding. Indexes above the list are dropped.
// Reset clears the configuration and control registers but not the output
// data register. Table entries are undefined until written and are not cleared.
`default_nettype none
`include "exception_index_table_search_macros.svh"

module exception_index_table_search import eits_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 1024,
  parameter int unsigned ENTRY_BYTES = 8
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // Configuration write channel
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [WORD_W-1:0]    cfg_data_i,
  // Input item channel
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic                 command_i,
  input  wire logic [SLOT_W-1:0]    entry_slot_i,
  input  wire logic [WORD_W-1:0]    entry_word_i,
  input  wire logic [WORD_W-1:0]    search_key_i,
  // Result channel
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [INDEX_W-1:0]        found_index_o,
  output logic [WORD_W-1:0]         found_address_o,
  output logic                      below_first_o
);

  eits_cfg_t    cfg_q;
  eits_req_t    req;
  eits_result_t res;
  eits_result_t out_q;
  logic         out_valid_q;
  logic         busy;
  logic         res_valid;
  logic         res_take;

  assign cfg_ready_o = 1'b1;

  // Latch configuration transfers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VALUE_MODE:  cfg_q.value_mode  <= cfg_data_i[0];
        CFG_TABLE_BASE:  cfg_q.table_base  <= cfg_data_i;
        CFG_ENTRY_COUNT: cfg_q.entry_count <= cfg_data_i[COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Accept input items only while the engine is free
  assign in_stall_o = busy;
  assign req.valid   = in_valid_i && !busy;
  assign req.command = command_i;
  assign req.slot    = entry_slot_i;
  assign req.word    = entry_word_i;
  assign req.key     = search_key_i;

  eits_search #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ENTRY_BYTES (ENTRY_BYTES)
  ) u_search (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .req_i       (req),
    .busy_o      (busy),
    .res_valid_o (res_valid),
    .res_take_i  (res_take),
    .res_o       (res)
  );

  // Move a result into the output register when it is free or draining
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign found_index_o   = out_q.index;
  assign found_address_o = out_q.address;
  assign below_first_o   = out_q.below;

  // A miss reports a zero index and address
  `EITS_ASSERT_SAME(a_below_zero, out_valid_o && below_first_o, (found_index_o == '0) && (found_address_o == '0), "miss result carries a nonzero index or address")
  // A found entry lies inside the searched range
  `EITS_ASSERT_SAME(a_index_range, out_valid_o && !below_first_o, 32'(found_index_o) < 32'(cfg_q.entry_count), "found index outside the searched range")
  // A query transfer occupies the engine in the next cycle
  `EITS_ASSERT_NEXT(a_query_busy, in_valid_i && !in_stall_o && (command_i == CMD_SEARCH), in_stall_o, "query accepted without starting a search")

endmodule

`default_nettype wire
